[src/ohs_pkg.sv]
// shared types and constants for the open-addressed hash set
// used by ohs_ctrl, ohs_dp and open_addressing_hash_set
package ohs_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_OCC = 2'd1;
	localparam logic [1:0] MARK_TOMB = 2'd2;

	localparam logic [1:0] REG_SIZE = 2'd0;
	localparam logic [1:0] REG_MOD = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;

	localparam int DEFAULT_SIZE = 13;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_HASH,
		S_ADDR,
		S_READ,
		S_EVAL,
		S_WRITE,
		S_CLEAR,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture op and key, start hashing
		logic hash_step;  // one home-slot step (division, sign fix-up or load)
		logic addr;       // compute probe slot for current index
		logic eval;       // look at the mark and key just read
		logic write;      // commit insert or delete
		logic clr_step;   // clear one slot
		logic finish;     // present result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hash_done;
		logic probe_stop;  // stop probing (hit, empty or path ended)
		logic need_write;
		logic clr_done;
	} dp_stat_t;

endpackage

[src/open_addressing_hash_set.sv]
// top level of the open-addressed hash set
// depends on ohs_pkg, ohs_ctrl, ohs_dp
// After reset busy stays high while the slot marks are swept empty. An insert,
// search or delete holds busy through the home-slot work (32 restoring steps over the key
// magnitude, a sign fix-up, seven steps reducing the home by the size in use, one load),
// then an address, read and evaluate state per probe, a write state when an insert or
// delete commits, and a state to present the result. A clear holds busy while every slot
// mark is swept empty and the result is presented. The result strobes on done for a single
// cycle, the first with busy low; the receiver cannot stall it, and start is taken
// only while busy is low, so the next word can be taken in that same cycle.
module open_addressing_hash_set #(
	parameter int SLOT_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic signed [31:0] key,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data,
	output logic              done,
	output logic [1:0]        status,
	output logic [6:0]        compare_count,
	output logic [6:0]        live_count,
	output logic [6:0]        tombstone_count
);
	logic [6:0] size_q, mod_q;
	logic       mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 7'd13;
			mod_q <= 7'd13;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ohs_pkg::REG_SIZE: size_q <= cfg_data;
				ohs_pkg::REG_MOD: mod_q <= cfg_data;
				ohs_pkg::REG_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ohs_pkg::dp_cmd_t  cmd;
	ohs_pkg::dp_stat_t stat;

	ohs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	ohs_dp #(.SLOT_DEPTH(SLOT_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.opcode(opcode), .key(key),
		.table_size(size_q), .hash_modulus(mod_q), .probe_mode(mode_q),
		.done(done), .status(status), .compare_count(compare_count),
		.live_count(live_count), .tombstone_count(tombstone_count)
	);
endmodule

[src/ohs_ram.sv]
// generic single-port ram with registered read
// no dependencies
module ohs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[src/ohs_ctrl.sv]
// controller state machine for the hash set
// depends on ohs_pkg
module ohs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        opcode,
	input  ohs_pkg::dp_stat_t stat,
	output ohs_pkg::dp_cmd_t  cmd,
	output logic              busy
);
	ohs_pkg::state_t state_q, state_d;

	// after reset the mark store is swept empty before the first word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ohs_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ohs_pkg::S_INIT: begin
				if (stat.clr_done) state_d = ohs_pkg::S_IDLE;
			end
			ohs_pkg::S_IDLE: begin
				if (start) begin
					state_d = (opcode == ohs_pkg::OP_CLEAR) ? ohs_pkg::S_CLEAR : ohs_pkg::S_HASH;
				end
			end
			ohs_pkg::S_HASH: begin
				if (stat.hash_done) state_d = ohs_pkg::S_ADDR;
			end
			ohs_pkg::S_ADDR: state_d = ohs_pkg::S_READ;
			ohs_pkg::S_READ: state_d = ohs_pkg::S_EVAL;
			ohs_pkg::S_EVAL: begin
				if (stat.probe_stop) begin
					state_d = stat.need_write ? ohs_pkg::S_WRITE : ohs_pkg::S_DONE;
				end else begin
					state_d = ohs_pkg::S_ADDR;
				end
			end
			ohs_pkg::S_WRITE: state_d = ohs_pkg::S_DONE;
			ohs_pkg::S_CLEAR: begin
				if (stat.clr_done) state_d = ohs_pkg::S_DONE;
			end
			ohs_pkg::S_DONE: state_d = ohs_pkg::S_IDLE;
			default: state_d = ohs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ohs_pkg::S_IDLE);
		unique case (state_q)
			ohs_pkg::S_INIT: cmd.clr_step = 1'b1;
			ohs_pkg::S_IDLE: cmd.load = start;
			ohs_pkg::S_HASH: cmd.hash_step = 1'b1;
			ohs_pkg::S_ADDR: cmd.addr = 1'b1;
			ohs_pkg::S_READ: ;
			ohs_pkg::S_EVAL: cmd.eval = 1'b1;
			ohs_pkg::S_WRITE: cmd.write = 1'b1;
			ohs_pkg::S_CLEAR: cmd.clr_step = 1'b1;
			ohs_pkg::S_DONE: cmd.finish = 1'b1;
			default: ;
		endcase
	end
endmodule

[src/ohs_dp.sv]
// datapath: home-slot divider, probe address, slot stores, counters
// depends on ohs_pkg and ohs_ram
module ohs_dp #(
	parameter int SLOT_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ohs_pkg::dp_cmd_t  cmd,
	output ohs_pkg::dp_stat_t stat,
	input  logic [1:0]        opcode,
	input  logic signed [31:0] key,
	input  logic [6:0]        table_size,
	input  logic [6:0]        hash_modulus,
	input  logic              probe_mode,
	output logic              done,
	output logic [1:0]        status,
	output logic [6:0]        compare_count,
	output logic [6:0]        live_count,
	output logic [6:0]        tombstone_count
);
	localparam int AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
	localparam int CW = $clog2(SLOT_DEPTH + 1);

	logic [1:0]  op_q;
	logic [31:0] key_q;
	logic        neg_q;
	logic [31:0] quo_q;     // dividend bits shifting out
	logic [6:0]  rem_q;
	logic [6:0]  hsh_q;     // home before reduction by the size
	logic [6:0]  hrem_q;
	logic [5:0]  hcnt_q;
	logic [6:0]  home_q;
	logic [6:0]  m_q;       // size in use
	logic [6:0]  p_q;       // modulus in use
	logic [6:0]  i_q;       // probe index
	logic [6:0]  lin_q;     // linear probe slot
	logic [6:0]  sq_q;      // k*k mod m
	logic [6:0]  odd_q;     // (2k+1) mod m
	logic [AW-1:0] slot_q;
	logic        tomb_have_q;
	logic [AW-1:0] tomb_at_q;
	logic [AW-1:0] wslot_q;
	logic [1:0]  wmark_q;
	logic [1:0]  st_q;
	logic [6:0]  cmp_q;
	logic [CW-1:0] occ_q, tmb_q;
	logic [AW-1:0] clr_q;
	logic        done_q;

	// keys and marks both in ram, marks swept empty after reset and on clear
	logic [1:0] mark_s2;
	logic [31:0] rkey;
	logic        kwe;
	logic [AW-1:0] kaddr;
	logic        mwe;
	logic [AW-1:0] maddr;
	logic [1:0]  mwdata;

	assign kwe = cmd.write && (op_q == ohs_pkg::OP_INSERT);
	assign kaddr = cmd.write ? wslot_q : slot_q;
	assign mwe = cmd.write || cmd.clr_step;
	assign maddr = cmd.clr_step ? clr_q : kaddr;
	assign mwdata = cmd.clr_step ? ohs_pkg::MARK_EMPTY : wmark_q;

	ohs_ram #(.WIDTH(32), .DEPTH(SLOT_DEPTH)) u_keys (
		.clk(clk), .we(kwe), .addr(kaddr), .wdata(key_q), .rdata(rkey)
	);

	ohs_ram #(.WIDTH(2), .DEPTH(SLOT_DEPTH)) u_marks (
		.clk(clk), .we(mwe), .addr(maddr), .wdata(mwdata), .rdata(mark_s2)
	);

	// size and modulus in use
	logic [6:0] m_use, p_use;
	always_comb begin
		m_use = (table_size == 7'd0) ? 7'(ohs_pkg::DEFAULT_SIZE) : table_size;
		if (32'(m_use) > 32'(SLOT_DEPTH)) m_use = 7'(SLOT_DEPTH);
		p_use = (hash_modulus < 7'd2) ? 7'd2 : hash_modulus;
	end

	// restoring division steps: |key| by p, then home by m
	logic [7:0] rtry;
	logic [7:0] mtry;
	assign rtry = {rem_q, quo_q[31]} - {1'b0, p_q};
	assign mtry = {hrem_q, hsh_q[6]} - {1'b0, m_q};

	// quadratic offsets kept mod m: k*k grows by 2k+1, which grows by 2
	logic [7:0] qsum, qdif, sq_t, odd_t;
	logic [6:0] two_m, sq_nx, odd_nx;
	logic [6:0] pidx;
	always_comb begin
		two_m = (m_q > 7'd2) ? 7'd2 : 7'd0;
		sq_t = {1'b0, sq_q} + {1'b0, odd_q};
		sq_nx = (sq_t >= {1'b0, m_q}) ? 7'(sq_t - {1'b0, m_q}) : sq_t[6:0];
		odd_t = {1'b0, odd_q} + {1'b0, two_m};
		odd_nx = (odd_t >= {1'b0, m_q}) ? 7'(odd_t - {1'b0, m_q}) : odd_t[6:0];
		qsum = {1'b0, home_q} + {1'b0, sq_q};
		qdif = {1'b0, home_q} - {1'b0, sq_q};
		if (probe_mode == 1'b0) begin
			pidx = lin_q;
		end else if (i_q[0]) begin
			pidx = (qsum >= {1'b0, m_q}) ? 7'(qsum - {1'b0, m_q}) : qsum[6:0];
		end else begin
			pidx = qdif[7] ? 7'(qdif + {1'b0, m_q}) : qdif[6:0];
		end
	end

	logic hit;
	assign hit = (mark_s2 == ohs_pkg::MARK_OCC) && (rkey == key_q);

	always_comb begin
		stat.hash_done = (hcnt_q == 6'd40);
		stat.clr_done = (32'(clr_q) == SLOT_DEPTH - 1);
		stat.need_write = 1'b0;
		stat.probe_stop = 1'b0;
		if (op_q == ohs_pkg::OP_INSERT) begin
			if (mark_s2 == ohs_pkg::MARK_EMPTY) begin
				stat.probe_stop = 1'b1;
				stat.need_write = 1'b1;
			end else if (hit) begin
				stat.probe_stop = 1'b1;
			end else if (i_q + 7'd1 == m_q) begin
				stat.probe_stop = 1'b1;
				stat.need_write = tomb_have_q || (mark_s2 == ohs_pkg::MARK_TOMB);
			end
		end else begin
			if (mark_s2 == ohs_pkg::MARK_EMPTY || hit || i_q + 7'd1 == m_q) begin
				stat.probe_stop = 1'b1;
				stat.need_write = (op_q == ohs_pkg::OP_DELETE) && hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			tmb_q <= '0;
			done_q <= 1'b0;
			hcnt_q <= '0;
			clr_q <= '0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				hcnt_q <= '0;
				clr_q <= '0;
			end
			if (cmd.hash_step) hcnt_q <= hcnt_q + 6'd1;
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
				occ_q <= '0;
				tmb_q <= '0;
			end
			if (cmd.write) begin
				if (op_q == ohs_pkg::OP_INSERT) begin
					occ_q <= occ_q + CW'(1);
					if (tomb_have_q) tmb_q <= tmb_q - CW'(1);
				end else begin
					occ_q <= occ_q - CW'(1);
					tmb_q <= tmb_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			key_q <= key;
			neg_q <= key[31];
			quo_q <= key[31] ? 32'(-key) : key;
			rem_q <= '0;
			m_q <= m_use;
			p_q <= p_use;
			i_q <= '0;
			sq_q <= '0;
			odd_q <= (m_use == 7'd1) ? 7'd0 : 7'd1;
			tomb_have_q <= 1'b0;
			st_q <= ohs_pkg::ST_OK;
			cmp_q <= '0;
		end
		if (cmd.hash_step) begin
			if (hcnt_q < 6'd32) begin
				if (!rtry[7]) rem_q <= rtry[6:0];
				else rem_q <= {rem_q[5:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end else if (hcnt_q == 6'd32) begin
				// non-negative residue, then seven steps reduce it by the size
				hsh_q <= (neg_q && rem_q != 7'd0) ? p_q - rem_q : rem_q;
				hrem_q <= '0;
			end else if (hcnt_q < 6'd40) begin
				if (!mtry[7]) hrem_q <= mtry[6:0];
				else hrem_q <= {hrem_q[5:0], hsh_q[6]};
				hsh_q <= {hsh_q[5:0], 1'b0};
			end else begin
				home_q <= hrem_q;
				lin_q <= hrem_q;
			end
		end
		if (cmd.addr) slot_q <= AW'(pidx);
		if (cmd.eval) begin
			i_q <= i_q + 7'd1;
			lin_q <= (lin_q + 7'd1 == m_q) ? 7'd0 : lin_q + 7'd1;
			if (!i_q[0]) begin
				sq_q <= sq_nx;
				odd_q <= odd_nx;
			end
			if (op_q == ohs_pkg::OP_INSERT) begin
				if (mark_s2 == ohs_pkg::MARK_TOMB && !tomb_have_q) begin
					tomb_have_q <= 1'b1;
					tomb_at_q <= slot_q;
				end
				wmark_q <= ohs_pkg::MARK_OCC;
				wslot_q <= tomb_have_q ? tomb_at_q : slot_q;
				if (hit) st_q <= ohs_pkg::ST_DUP;
				else if (stat.probe_stop && !stat.need_write) st_q <= ohs_pkg::ST_FULL;
			end else begin
				wmark_q <= ohs_pkg::MARK_TOMB;
				wslot_q <= slot_q;
				if (op_q == ohs_pkg::OP_SEARCH && mark_s2 == ohs_pkg::MARK_OCC)
					cmp_q <= cmp_q + 7'd1;
				if (stat.probe_stop) st_q <= hit ? ohs_pkg::ST_OK : ohs_pkg::ST_MISSING;
			end
		end
	end

	assign done = done_q;
	assign status = st_q;
	assign compare_count = cmp_q;
	assign live_count = 7'(occ_q);
	assign tombstone_count = 7'(tmb_q);
endmodule
